// ===== hw/rtl/vertex_attribute_normalizer_macros.svh =====
// Assertion helpers for the vertex attribute normalizer.
`ifndef VERTEX_ATTRIBUTE_NORMALIZER_MACROS_SVH
`define VERTEX_ATTRIBUTE_NORMALIZER_MACROS_SVH

// Property that must hold at the same edge.
`define VAN_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("van check failed");

// Property that must hold at the next edge.
`define VAN_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("van check failed");

`endif

// ===== hw/rtl/van_pkg.sv =====
`timescale 1ns / 1ps
package van_pkg;
    localparam int INDEX_BITS = 24;
    localparam int LANES      = 4;
    localparam int MAG_W      = 65;   // 1 integer bit + 64 fraction bits
    localparam int LZ_W       = 7;

    localparam logic [2:0] FMT_S8  = 3'd0;
    localparam logic [2:0] FMT_U8  = 3'd1;
    localparam logic [2:0] FMT_S16 = 3'd2;
    localparam logic [2:0] FMT_U16 = 3'd3;
    localparam logic [2:0] FMT_S32 = 3'd4;
    localparam logic [2:0] FMT_U32 = 3'd5;
    localparam logic [2:0] FMT_F32 = 3'd6;

    localparam logic [2:0] KIND_POSITION = 3'd0;
    localparam logic [2:0] KIND_NORMAL   = 3'd1;
    localparam logic [2:0] KIND_TANGENT  = 3'd2;
    localparam logic [2:0] KIND_TEXCOORD = 3'd3;
    localparam logic [2:0] KIND_COLOR    = 3'd4;

    localparam logic [1:0] CFG_KIND   = 2'd0;
    localparam logic [1:0] CFG_FORMAT = 2'd1;
    localparam logic [1:0] CFG_STRIDE = 2'd2;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

    // Leading zero count of the 65-bit magnitude (zero input is handled apart).
    function automatic logic [LZ_W-1:0] van_lzc(input logic [MAG_W-1:0] m);
        logic [LZ_W-1:0] lz;
        lz = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) begin
                lz = LZ_W'(MAG_W - 1 - i);
            end
        end
        return lz;
    endfunction
endpackage

// ===== hw/rtl/van_in_if.sv =====
`timescale 1ns / 1ps
interface van_in_if import van_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] vertex_index;
    logic [31:0]           raw_comp0;
    logic [31:0]           raw_comp1;
    logic [31:0]           raw_comp2;
    logic [31:0]           raw_comp3;
    logic                  is_last;

    modport source (output valid, vertex_index, raw_comp0, raw_comp1, raw_comp2, raw_comp3,
                    is_last, input ready);
    modport sink (input valid, vertex_index, raw_comp0, raw_comp1, raw_comp2, raw_comp3,
                  is_last, output ready);
endinterface

// ===== hw/rtl/van_out_if.sv =====
`timescale 1ns / 1ps
interface van_out_if import van_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] out_vertex_index;
    logic [31:0]           source_offset;
    logic [31:0]           value0;
    logic [31:0]           value1;
    logic [31:0]           value2;
    logic [31:0]           value3;
    logic [2:0]            lanes_used;
    logic                  last_out;

    modport source (output valid, out_vertex_index, source_offset, value0, value1, value2,
                    value3, lanes_used, last_out, input ready);
    modport sink (input valid, out_vertex_index, source_offset, value0, value1, value2,
                  value3, lanes_used, last_out, output ready);
endinterface

// ===== hw/rtl/van_lane.sv =====
`timescale 1ns / 1ps
// One component lane: operand prep, leading zero count, normalize and round.
module van_lane import van_pkg::*; (
    input  logic        i_clk,
    input  t_pipe_ctl   i_ctl,
    input  logic [31:0] i_raw,
    input  logic [2:0]  i_fmt,
    input  logic        i_used,
    input  logic        i_flip,
    output logic [31:0] o_value
);
    // stage 1: magnitude as fixed point, exponent base, sign
    logic [16:0]      n_mag;
    logic [16:0]      n_den;
    logic             n_q0;
    logic [15:0]      n_rem;
    logic [32:0]      n_mag32;
    logic [69:0]      n_rep7;
    logic [63:0]      n_rep8;
    logic [74:0]      n_rep15;
    logic [63:0]      n_rep16;
    logic [MAG_W-1:0] n_m1;
    logic [7:0]       n_e1;
    logic             n_neg1;
    logic             n_pass1;
    logic [31:0]      n_pval1;

    logic [MAG_W-1:0] r_m1;
    logic [7:0]       r_e1;
    logic             r_neg1;
    logic             r_pass1;
    logic [31:0]      r_pval1;
    logic             r_flip1;

    always_comb begin
        n_mag   = '0;
        n_den   = 17'd127;
        n_neg1  = 1'b0;
        n_pass1 = 1'b0;
        n_e1    = 8'd127;
        n_mag32 = '0;
        unique case (i_fmt)
            FMT_S8: begin
                n_neg1 = i_raw[7];
                n_mag  = n_neg1 ? 17'(9'd256 - {1'b0, i_raw[7:0]}) : {9'd0, i_raw[7:0]};
                n_den  = 17'd127;
            end
            FMT_U8: begin
                n_mag = {9'd0, i_raw[7:0]};
                n_den = 17'd255;
            end
            FMT_S16: begin
                n_neg1 = i_raw[15];
                n_mag  = n_neg1 ? 17'(17'h10000 - {1'b0, i_raw[15:0]}) : {1'b0, i_raw[15:0]};
                n_den  = 17'd32767;
            end
            FMT_U16: begin
                n_mag = {1'b0, i_raw[15:0]};
                n_den = 17'd65535;
            end
            // top bit of the 65-bit field is magnitude bit 32: 2^32 / 2^31 = 2^1
            FMT_S32: begin
                n_neg1  = i_raw[31];
                n_mag32 = n_neg1 ? 33'(33'h100000000 - {1'b0, i_raw}) : {1'b0, i_raw};
                n_e1    = 8'd128;
            end
            // top bit is magnitude bit 32: 2^32 / 2^32 = 2^0
            FMT_U32: begin
                n_mag32 = {1'b0, i_raw};
                n_e1    = 8'd127;
            end
            default: n_pass1 = 1'b1;
        endcase

        // n / (2^k - 1) = q0 + fraction made of the k-bit remainder repeated
        n_q0    = (n_mag >= n_den);
        n_rem   = 16'(n_q0 ? n_mag - n_den : n_mag);
        n_rep7  = {10{n_rem[6:0]}};
        n_rep8  = {8{n_rem[7:0]}};
        n_rep15 = {5{n_rem[14:0]}};
        n_rep16 = {4{n_rem[15:0]}};

        unique case (i_fmt)
            FMT_S8:  n_m1 = {n_q0, n_rep7[69:6]};
            FMT_U8:  n_m1 = {n_q0, n_rep8};
            FMT_S16: n_m1 = {n_q0, n_rep15[74:11]};
            FMT_U16: n_m1 = {n_q0, n_rep16};
            default: n_m1 = {n_mag32, 32'd0};
        endcase

        if (!i_used) begin
            n_pass1 = 1'b1;
            n_pval1 = '0;
        end else begin
            n_pval1 = i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_m1    <= n_m1;
            r_e1    <= n_e1;
            r_neg1  <= n_neg1;
            r_pass1 <= n_pass1;
            r_pval1 <= n_pval1;
            r_flip1 <= i_flip;
        end
    end

    // stage 2: leading zero count
    logic [MAG_W-1:0] r_m2;
    logic [LZ_W-1:0]  r_lz2;
    logic [7:0]       r_e2;
    logic             r_neg2;
    logic             r_pass2;
    logic [31:0]      r_pval2;
    logic             r_flip2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_m2    <= r_m1;
            r_lz2   <= van_lzc(r_m1);
            r_e2    <= r_e1;
            r_neg2  <= r_neg1;
            r_pass2 <= r_pass1;
            r_pval2 <= r_pval1;
            r_flip2 <= r_flip1;
        end
    end

    // stage 3: normalize, round to nearest even, pack
    logic [MAG_W-1:0] n_norm;
    logic             n_guard;
    logic             n_sticky;
    logic             n_up;
    logic [24:0]      n_sum;
    logic [22:0]      n_frac;
    logic [7:0]       n_exp;
    logic [31:0]      n_val3;
    logic [31:0]      r_val3;

    always_comb begin
        n_norm   = r_m2 << r_lz2;
        n_guard  = n_norm[40];
        n_sticky = |n_norm[39:0];
        n_up     = n_guard & (n_sticky | n_norm[41]);
        n_sum    = {1'b0, 1'b1, n_norm[63:41]} + {24'd0, n_up};
        n_frac   = n_sum[24] ? n_sum[23:1] : n_sum[22:0];
        n_exp    = r_e2 - 8'(r_lz2) + {7'd0, n_sum[24]};
        if (r_pass2) begin
            n_val3 = r_pval2;
        end else if (r_m2 == '0) begin
            n_val3 = '0;
        end else begin
            n_val3 = {r_neg2, n_exp, n_frac};
        end
        n_val3 = n_val3 ^ {r_flip2, 31'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_val3 <= n_val3;
        end
    end

    assign o_value = r_val3;
endmodule

// ===== hw/rtl/vertex_attribute_normalizer.sv =====
`timescale 1ns / 1ps
// Vertex attribute normalizer: turns each item (a vertex index and four raw
// components) into four IEEE single values under the configured component
// format and attribute kind. Integer formats are divided by the format
// maximum (s32 by 2^31, u32 by 2^32) and rounded once to nearest even, with
// no clamping; float32 passes bit for bit; lanes past the attribute's
// component count read +0.0 and position z has its sign flipped. Each result
// also carries vertex_index * stride_bytes (mod 2^32). Three register stages
// (operand prep with the offset multiply, 65-bit leading zero count,
// normalize/round); one item is taken every cycle unless all stages are full
// and the output is stalled; stalls back up stage by stage, and empty stages
// are filled while the output waits. The user must write configuration through
// i_cfg_we/i_cfg_idx/i_cfg_data only while the block is idle (not enforced).
module vertex_attribute_normalizer import van_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    van_in_if.sink     i_in,
    van_out_if.source  o_out
);
`include "vertex_attribute_normalizer_macros.svh"

    // config registers
    logic [2:0] r_kind;
    logic [2:0] r_fmt;
    logic [7:0] r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_POSITION;
            r_fmt    <= FMT_F32;
            r_stride <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KIND:   r_kind   <= i_cfg_data[2:0];
                CFG_FORMAT: r_fmt    <= i_cfg_data[2:0];
                CFG_STRIDE: r_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // component count; unknown kinds act as color
    logic [2:0] n_lanes;
    always_comb begin
        unique case (r_kind)
            KIND_POSITION, KIND_NORMAL: n_lanes = 3'd3;
            KIND_TEXCOORD:              n_lanes = 3'd2;
            default:                    n_lanes = 3'd4;
        endcase
    end

    // stall chain: a stage moves when it is empty or the next one moves
    logic      r_v1, r_v2, r_v3;
    t_pipe_ctl ctl;

    assign ctl.en3    = !r_v3 || o_out.ready;
    assign ctl.en2    = !r_v2 || ctl.en3;
    assign ctl.en1    = !r_v1 || ctl.en2;
    assign i_in.ready = ctl.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ctl.en1) r_v1 <= i_in.valid;
            if (ctl.en2) r_v2 <= r_v1;
            if (ctl.en3) r_v3 <= r_v2;
        end
    end

    // side payload: index, offset, lane count, last flag
    logic [INDEX_BITS-1:0] r_idx1, r_idx2, r_idx3;
    logic [31:0]           r_off1, r_off2, r_off3;
    logic [2:0]            r_lanes1, r_lanes2, r_lanes3;
    logic                  r_last1, r_last2, r_last3;
    logic [31:0]           n_off;

    assign n_off = 32'(i_in.vertex_index) * 32'(r_stride);

    always_ff @(posedge i_clk) begin
        if (ctl.en1) begin
            r_idx1   <= i_in.vertex_index;
            r_off1   <= n_off;
            r_lanes1 <= n_lanes;
            r_last1  <= i_in.is_last;
        end
        if (ctl.en2) begin
            r_idx2   <= r_idx1;
            r_off2   <= r_off1;
            r_lanes2 <= r_lanes1;
            r_last2  <= r_last1;
        end
        if (ctl.en3) begin
            r_idx3   <= r_idx2;
            r_off3   <= r_off2;
            r_lanes3 <= r_lanes2;
            r_last3  <= r_last2;
        end
    end

    // component lanes
    logic [31:0] raw  [LANES];
    logic [31:0] vals [LANES];

    assign raw[0] = i_in.raw_comp0;
    assign raw[1] = i_in.raw_comp1;
    assign raw[2] = i_in.raw_comp2;
    assign raw[3] = i_in.raw_comp3;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        van_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_raw   (raw[g]),
            .i_fmt   (r_fmt),
            .i_used  (3'(g) < n_lanes),
            .i_flip  ((g == 2) && (r_kind == KIND_POSITION)),
            .o_value (vals[g])
        );
    end

    assign o_out.valid            = r_v3;
    assign o_out.out_vertex_index = r_idx3;
    assign o_out.source_offset    = r_off3;
    assign o_out.value0           = vals[0];
    assign o_out.value1           = vals[1];
    assign o_out.value2           = vals[2];
    assign o_out.value3           = vals[3];
    assign o_out.lanes_used       = r_lanes3;
    assign o_out.last_out         = r_last3;

    // a refused input means every stage holds an item
    `VAN_ASSERT_NOW(a_full_on_stall, i_clk, i_rst_n, !i_in.ready, r_v1 && r_v2 && r_v3)
    // unused lanes read +0.0
    `VAN_ASSERT_NOW(a_two_lanes, i_clk, i_rst_n, r_v3 && (r_lanes3 == 3'd2), (vals[2] == 32'd0) && (vals[3] == 32'd0))
    `VAN_ASSERT_NOW(a_three_lanes, i_clk, i_rst_n, r_v3 && (r_lanes3 == 3'd3), vals[3] == 32'd0)
    // a waiting result does not disappear under a stall
    `VAN_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, r_v2 && r_v3 && !o_out.ready, r_v3 && r_v2)
endmodule
